// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL (dtq_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/dtq_pkg.sv =====
`default_nettype none
package dtq_pkg;
  localparam int NUM_TIMERS = 16;
  localparam int ID_W       = 4;
  localparam int TIME_W     = 32;
  localparam int SEQ_W      = 32;
  localparam int CNT_W      = 5;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  typedef enum logic [1:0] {OP_TICK, OP_START, OP_STOP} op_t;
  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_RANK, ST_EMIT} state_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] timeout;
    logic              periodic;
  } cmd_t;

  typedef struct packed {
    logic            valid;
    cmd_t            cmd;
  } cmd_link_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            per;
    logic            last;
  } res_t;

  // Order-preserving key of the signed distance to the deadline.
  function automatic logic [TIME_W-1:0] due_key(input logic [TIME_W-1:0] dl,
                                                input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] d;
    d = dl - now;
    return {~d[TIME_W-1], d[TIME_W-2:0]};
  endfunction
endpackage
`default_nettype wire

// ===== sv/deadline_timer_queue.sv =====
// Table of 16 software timers with deadline-ordered expiry reports.
// Input queue: drive mode, timer_id, timeout, periodic and raise push;
// the command is taken at an edge with push high and full low. Mode 1
// arms or re-arms a slot, mode 2 disarms it, mode 0 is a tick, mode 3 is
// dropped. Result queue: while empty is low, expired_id, was_periodic and
// last show the oldest report; pop takes it.
// A command sits in a two-entry queue before the executor. Start and stop
// act as they are taken. A tick is taken, then due slots are marked, then
// every slot counts the due slots ahead of it against one broadcast slot a
// cycle until all 16 slots have been broadcast, then the reports go out in
// rank order and the executor returns to idle once the last one is out.
// Reports land in a two-entry queue; when it is full and pop stays low,
// the executor holds, and once the command queue fills too, full rises.
// Reset disarms every slot and zeroes the time count and arming sequence;
// both queues come out of reset empty.
`default_nettype none
module deadline_timer_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 mode,
  input  wire logic [dtq_pkg::ID_W-1:0]   timer_id,
  input  wire logic [dtq_pkg::TIME_W-1:0] timeout,
  input  wire logic                       periodic,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [dtq_pkg::ID_W-1:0]        expired_id,
  output logic                            was_periodic,
  output logic                            last
);
  import dtq_pkg::*;

  cmd_link_t link;
  logic      link_pop;

  dtq_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode),
    .timer_id(timer_id), .timeout(timeout), .periodic(periodic),
    .link(link), .link_pop(link_pop)
  );

  dtq_back u_back (
    .clk(clk), .rst(rst), .link(link), .link_pop(link_pop),
    .empty(empty), .pop(pop), .expired_id(expired_id),
    .was_periodic(was_periodic), .last(last)
  );
endmodule
`default_nettype wire

// ===== sv/dtq_front.sv =====
`default_nettype none
module dtq_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [1:0]                 mode,
  input  wire logic [dtq_pkg::ID_W-1:0]   timer_id,
  input  wire logic [dtq_pkg::TIME_W-1:0] timeout,
  input  wire logic                       periodic,
  output dtq_pkg::cmd_link_t              link,
  input  wire logic                       link_pop
);
  import dtq_pkg::*;

  cmd_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       keep;
  cmd_t       cls;
  logic       wr, rd;

  // Classify: drop unknown modes at the door.
  always_comb begin
    keep = 1'b1;
    cls.id = timer_id;
    cls.timeout = timeout;
    cls.periodic = periodic;
    unique case (mode)
      MODE_TICK:  cls.op = OP_TICK;
      MODE_START: cls.op = OP_START;
      MODE_STOP:  cls.op = OP_STOP;
      default: begin
        cls.op = OP_TICK;
        keep = 1'b0;
      end
    endcase
  end

  assign full = (count == 2'd2);
  assign wr = push && !full && keep;
  assign rd = link_pop && (count != 2'd0);
  assign link.valid = (count != 2'd0);
  assign link.cmd = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= ~wptr;
      if (rd) rptr <= ~rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// ===== sv/dtq_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module dtq_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dtq_pkg::cmd_link_t       link,
  output logic                          link_pop,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [dtq_pkg::ID_W-1:0]      expired_id,
  output logic                          was_periodic,
  output logic                          last
);
  import dtq_pkg::*;

  state_t state, state_next;

  logic [NUM_TIMERS-1:0] armed;
  logic [TIME_W-1:0]     deadline [NUM_TIMERS];
  logic [TIME_W-1:0]     reload [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] rep;
  logic [SEQ_W-1:0]      order [NUM_TIMERS];
  logic [TIME_W-1:0]     now;
  logic [SEQ_W-1:0]      seq;

  logic [NUM_TIMERS-1:0] due;
  logic [ID_W-1:0]       rank [NUM_TIMERS];
  logic [ID_W-1:0]       j;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      r;

  logic [TIME_W-1:0]     key [NUM_TIMERS];
  logic [SEQ_W-1:0]      age [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] due_c;
  logic [NUM_TIMERS-1:0] prec;
  logic [NUM_TIMERS-1:0] hit;
  logic [ID_W-1:0]       sel;
  logic                  emit;
  logic                  ofull;

  res_t       omem [2];
  logic       owp, orp;
  logic [1:0] ocnt;
  logic       ord;

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      key[i] = due_key(deadline[i], now);
      age[i] = seq - order[i];
      due_c[i] = armed[i] && (deadline[i] == now || key[i][TIME_W-1] == 1'b0);
      prec[i] = due[j] && (key[j] < key[i] || (key[j] == key[i] &&
                (age[j] > age[i] || (age[j] == age[i] && j < ID_W'(i)))));
      hit[i] = due[i] && (rank[i] == r[ID_W-1:0]);
    end
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (hit[i]) sel = ID_W'(i);
    end
  end

  assign ofull = (ocnt == 2'd2);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (link.valid && link.cmd.op == OP_TICK) state_next = ST_PREP;
      ST_PREP: state_next = ST_RANK;
      ST_RANK: if (j == ID_W'(NUM_TIMERS - 1)) state_next = ST_EMIT;
      ST_EMIT: if (r == cnt) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    link_pop = 1'b0;
    emit = 1'b0;
    unique case (state)
      ST_IDLE: link_pop = link.valid;
      ST_EMIT: emit = (r != cnt) && !ofull;
      default: begin
        link_pop = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      armed <= '0;
      now <= '0;
      seq <= '0;
    end else begin
      state <= state_next;
      if (link_pop) begin
        unique case (link.cmd.op)
          OP_TICK:  now <= now + 1'b1;
          OP_START: begin
            armed[link.cmd.id] <= 1'b1;
            seq <= seq + 1'b1;
          end
          OP_STOP:  armed[link.cmd.id] <= 1'b0;
          default:  now <= now;
        endcase
      end
      if (emit) begin
        if (rep[sel]) seq <= seq + 1'b1;
        else armed[sel] <= 1'b0;
      end
    end
  end

  // Slot table and ranking datapath.
  always_ff @(posedge clk) begin
    if (link_pop && link.cmd.op == OP_START) begin
      reload[link.cmd.id] <= link.cmd.timeout;
      rep[link.cmd.id] <= link.cmd.periodic;
      deadline[link.cmd.id] <= now + link.cmd.timeout;
      order[link.cmd.id] <= seq;
    end
    if (emit && rep[sel]) begin
      deadline[sel] <= now + reload[sel];
      order[sel] <= seq;
    end
    if (state == ST_PREP) begin
      due <= due_c;
      cnt <= CNT_W'($countones(due_c));
      j <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) rank[i] <= '0;
    end
    if (state == ST_RANK) begin
      j <= j + 1'b1;
      r <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (prec[i]) rank[i] <= rank[i] + 1'b1;
      end
    end
    if (emit) r <= r + 1'b1;
  end

  // Result queue.
  assign empty = (ocnt == 2'd0);
  assign ord = pop && !empty;
  assign expired_id = omem[orp].id;
  assign was_periodic = omem[orp].per;
  assign last = omem[orp].last;

  always_ff @(posedge clk) begin
    if (emit) begin
      omem[owp] <= '{id: sel, per: rep[sel], last: (r + 1'b1 == cnt)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= 1'b0;
      orp <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (emit) owp <= ~owp;
      if (ord) orp <= ~orp;
      ocnt <= ocnt + {1'b0, emit} - {1'b0, ord};
    end
  end

  `ASSERT_IMP(a_ocnt_max, clk, rst, 1'b1, ocnt != 2'd3)
  `ASSERT_IMP(a_rank_unique, clk, rst, state == ST_EMIT, $onehot0(hit))
  `ASSERT_IMP(a_emit_hits, clk, rst, emit, hit != '0)
  `ASSERT_NEXT(a_rank_done, clk, rst, state == ST_RANK && j == ID_W'(NUM_TIMERS - 1),
               state == ST_EMIT && r == '0)
endmodule
`default_nettype wire

// ===== tb/tb_deadline_timer_queue.sv =====
`default_nettype none
class timer_scoreboard;
  logic [31:0] now_cnt;
  logic [31:0] arm_seq;
  logic        armed_q [16];
  logic [31:0] due_at [16];
  logic [31:0] period [16];
  logic        rearm [16];
  logic [31:0] armed_at [16];
  logic [5:0]  expect_q [$];
  int          errors;

  function void reset_state();
    now_cnt = '0;
    arm_seq = '0;
    foreach (armed_q[i]) armed_q[i] = 1'b0;
    expect_q.delete();
    errors = 0;
  endfunction

  function void arm(int s, logic [31:0] t, logic per);
    period[s] = t;
    rearm[s] = per;
    due_at[s] = now_cnt + t;
    armed_at[s] = arm_seq;
    arm_seq = arm_seq + 1;
    armed_q[s] = 1'b1;
  endfunction

  // Predict the reports caused by one accepted command beat.
  function void note_command(logic [1:0] m, logic [3:0] id, logic [31:0] t, logic per);
    logic done [16];
    logic [31:0] d, k, bkey, age, bage;
    int best, n;
    if (m == dtq_pkg::MODE_START) begin
      arm(id, t, per);
      return;
    end
    if (m == dtq_pkg::MODE_STOP) begin
      armed_q[id] = 1'b0;
      return;
    end
    if (m != dtq_pkg::MODE_TICK) return;
    now_cnt = now_cnt + 1;
    foreach (done[i]) done[i] = 1'b0;
    n = 0;
    while (n < 16) begin
      best = -1;
      bkey = '0;
      bage = '0;
      for (int s = 0; s < 16; s++) begin
        if (!armed_q[s] || done[s]) continue;
        d = due_at[s] - now_cnt;
        if (d != 0 && !d[31]) continue;
        k = d ^ 32'h8000_0000;
        age = arm_seq - armed_at[s];
        if (best < 0 || k < bkey || (k == bkey && age > bage)) begin
          best = s;
          bkey = k;
          bage = age;
        end
      end
      if (best < 0) break;
      done[best] = 1'b1;
      expect_q.push_back({best[3:0], rearm[best], 1'b0});
      if (rearm[best]) arm(best, period[best], 1'b1);
      else armed_q[best] = 1'b0;
      n++;
    end
    if (n > 0) expect_q[expect_q.size()-1][0] = 1'b1;
  endfunction

  function void check_report(logic [3:0] id, logic per, logic lst);
    logic [5:0] e;
    if (expect_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected report id=%0d per=%0d last=%0d", id, per, lst);
      return;
    end
    e = expect_q.pop_front();
    if (e !== {id, per, lst}) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp id=%0d per=%0d last=%0d, got id=%0d per=%0d last=%0d",
                 e[5:2], e[1], e[0], id, per, lst);
    end
  endfunction
endclass

module tb_deadline_timer_queue;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  mode = dtq_pkg::MODE_TICK;
  logic [3:0]  timer_id = '0;
  logic [31:0] timeout = 32'd1;
  logic        periodic = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  expired_id;
  logic        was_periodic;
  logic        last;

  timer_scoreboard sb = new();
  bit  hold_off = 1'b0;
  int  idle_cycles = 0;

  deadline_timer_queue u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && push && !full) sb.note_command(mode, timer_id, timeout, periodic);
    if (!rst && pop && !empty) sb.check_report(expired_id, was_periodic, last);
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(logic [1:0] m, logic [3:0] id, logic [31:0] t, logic per);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    mode <= m;
    timer_id <= id;
    timeout <= t;
    periodic <= per;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    push <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expect_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        pop <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      pop <= 1'b0;
      repeat (w) @(negedge clk);
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic [1:0] m;
    sb.reset_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: extremes, stop of idle slot, mode 3, zero and huge timeouts, ties.
    send(dtq_pkg::MODE_STOP, 4'd5, 32'hFFFF_FFFF, 1'b1);
    send(2'd3, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send(dtq_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0);
    send(dtq_pkg::MODE_START, 4'd0, 32'd0, 1'b0);
    send(dtq_pkg::MODE_START, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send(dtq_pkg::MODE_START, 4'd7, 32'h8000_0000, 1'b0);
    send(dtq_pkg::MODE_START, 4'd3, 32'd1, 1'b1);
    send(dtq_pkg::MODE_START, 4'd9, 32'd1, 1'b0);
    send(dtq_pkg::MODE_START, 4'd2, 32'd2, 1'b0);
    send(dtq_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0);
    send(dtq_pkg::MODE_START, 4'd9, 32'd3, 1'b1);
    send(dtq_pkg::MODE_STOP, 4'd15, 32'd0, 1'b0);
    send(dtq_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0);
    send(dtq_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0);
    for (int i = 0; i < 16; i++) send(dtq_pkg::MODE_START, i[3:0], 32'd1, i[0]);
    send(dtq_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0);
    // Long receiver stall while commands keep coming.
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send(dtq_pkg::MODE_TICK, 4'd0, 32'd0, 1'b0);
    drain();
    // Random: mostly short timeouts so expiries are frequent.
    for (int i = 0; i < 75; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: m = dtq_pkg::MODE_TICK;
        4, 5, 6, 7: m = dtq_pkg::MODE_START;
        8: m = dtq_pkg::MODE_STOP;
        default: m = 2'd3;
      endcase
      send(m, 4'($urandom_range(0, 15)),
           ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 6),
           1'($urandom_range(0, 1)));
      if (i == 37) drain();
    end
    drain();
    if (sb.errors == 0 && sb.expect_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/dtq_pkg.sv
sv/dtq_front.sv
sv/dtq_back.sv
sv/deadline_timer_queue.sv
tb/tb_deadline_timer_queue.sv
